>>> src/assert_macros.svh
//==============================================================================
// Assertion macros
// Short forms for the concurrent assertions of the toroidal life block.
//==============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, switched off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> src/lts_pkg.sv
//==============================================================================
// Toroidal life package
// Field widths, mode codes, register indexes and the controller state type.
//==============================================================================
package lts_pkg;

    // Payload field widths.
    localparam int MODE_W  = 2;
    localparam int COORD_W = 6;
    localparam int CFG_W   = 7;
    localparam int CFG_IDX_W = 1;

    // Transaction modes.
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STEP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

    // Board size after reset, before clamping to the board maximum.
    localparam int RESET_SIZE = 10;

    // Rule B3/S23 neighbor counts.
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ACCESS,
        S_STEP,
        S_DONE
    } t_state;

endpackage

>>> src/lts_in_if.sv
//==============================================================================
// Toroidal life command channel
// Valid/ready channel carrying one write, step or read command.
//==============================================================================
interface lts_in_if;
    import lts_pkg::*;

    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               cell_in;

    modport source (output valid, output mode, output row, output col, output cell_in,
                    input ready);
    modport sink   (input valid, input mode, input row, input col, input cell_in,
                    output ready);
endinterface

>>> src/lts_out_if.sv
//==============================================================================
// Toroidal life result channel
// Valid/ready channel carrying one result per command.
//==============================================================================
interface lts_out_if;
    import lts_pkg::*;

    logic valid;
    logic ready;
    logic cell_out;
    logic status;

    modport source (output valid, output cell_out, output status, input ready);
    modport sink   (input valid, input cell_out, input status, output ready);
endinterface

>>> src/life_automaton_toroidal_step.sv
//==============================================================================
// Toroidal life board
// Cell board in a row-wide memory, with cell write, cell read and a full
// B3/S23 generation step swept one row per cycle.
//==============================================================================
//
//  Channel   Direction  Content
//  --------  ---------  -------------------------------------------------
//  i_in      in         mode, row, col, cell_in (one command)
//  o_out     out        cell_out, status (one result per command)
//  i_cfg_*   in         write of rows_in_use (index 0) or cols_in_use (1)
//
//  A write or read transaction passes from acceptance to a loaded result
//  through a memory read, a modify/decide step and a hand-off state.
//  During a step the single read port streams the rows through a
//  three-row window, and each new row is written back after its lower
//  neighbor was read. After reset the board memory is cleared one row per
//  cycle, all MAX_ROWS rows; no command is accepted meanwhile, configuration
//  writes are. A stalled result waits in the output register while the next
//  command is accepted; a second finished result then waits in the hand-off
//  state.
//
module life_automaton_toroidal_step #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    lts_in_if.sink                         i_in,
    lts_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [lts_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lts_pkg::CFG_W-1:0]      i_cfg_data
);
    import lts_pkg::*;

    localparam int RA_W  = $clog2(MAX_ROWS);
    localparam int CA_W  = $clog2(MAX_COLS);
    localparam int CW    = $clog2(MAX_ROWS + 4);
    localparam int CMP_W = CW + CFG_W;

    // Reset sizes, clamped to the board.
    localparam logic [CFG_W-1:0] ROWS_RST =
        (MAX_ROWS < RESET_SIZE) ? CFG_W'(MAX_ROWS) : CFG_W'(RESET_SIZE);
    localparam logic [CFG_W-1:0] COLS_RST =
        (MAX_COLS < RESET_SIZE) ? CFG_W'(MAX_COLS) : CFG_W'(RESET_SIZE);

    // Controller state.
    t_state           r_state, n_state;
    logic [CW-1:0]    r_cnt, n_cnt;

    // Configuration.
    logic [CFG_W-1:0] r_rows, r_cols;
    logic [CFG_W-1:0] cfg_rows_clamped, cfg_cols_clamped;

    // Captured command.
    logic [MODE_W-1:0]  r_mode;
    logic [COORD_W-1:0] r_row, r_col;
    logic               r_cell_in;
    logic               r_hit;
    logic               in_hit;

    // Board memory, one word per row.
    logic [MAX_COLS-1:0] r_board [MAX_ROWS];
    logic [MAX_COLS-1:0] r_rd_data;
    logic                rd_en, wr_en;
    logic [RA_W-1:0]     rd_addr, wr_addr;
    logic [MAX_COLS-1:0] wr_data;

    // Step window: rows r-1, r and r+1 of the old generation, plus the old
    // row 0 kept for the wrap of the last row.
    logic [MAX_COLS-1:0] r_win [3];
    logic [MAX_COLS-1:0] r_row0;
    logic [MAX_COLS-1:0] nb_left [3];
    logic [MAX_COLS-1:0] nb_right [3];
    logic [3:0]          nsum [MAX_COLS];
    logic [MAX_COLS-1:0] step_row;
    logic [CA_W-1:0]     last_col;

    // Counter and size compared at a common width.
    logic [CMP_W-1:0] cnt_x, rows_x;

    // Access path.
    logic [CA_W-1:0]     col_idx;
    logic [MAX_COLS-1:0] mod_word;
    logic                res_cell, res_status;
    logic                r_res_cell, r_res_status;

    // Output register.
    logic r_out_valid, r_out_cell, r_out_status;
    logic in_ready;
    logic out_free;

    assign cnt_x  = CMP_W'(r_cnt);
    assign rows_x = CMP_W'(r_rows);

    //--------------------------------------------------------------------------
    // Configuration: zero reads as one, anything above the board as its size.
    //--------------------------------------------------------------------------
    assign cfg_rows_clamped = (i_cfg_data == '0) ? CFG_W'(1) :
                              (32'(i_cfg_data) > MAX_ROWS) ? CFG_W'(MAX_ROWS) : i_cfg_data;
    assign cfg_cols_clamped = (i_cfg_data == '0) ? CFG_W'(1) :
                              (32'(i_cfg_data) > MAX_COLS) ? CFG_W'(MAX_COLS) : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= ROWS_RST;
            r_cols <= COLS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROWS: r_rows <= cfg_rows_clamped;
                CFG_COLS: r_cols <= cfg_cols_clamped;
                default: ;
            endcase
        end
    end

    //--------------------------------------------------------------------------
    // Command capture. A coordinate is in range only inside the used region.
    //--------------------------------------------------------------------------
    assign in_hit = ({1'b0, i_in.row} < r_rows) && ({1'b0, i_in.col} < r_cols);

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_mode    <= i_in.mode;
            r_row     <= i_in.row;
            r_col     <= i_in.col;
            r_cell_in <= i_in.cell_in;
            r_hit     <= in_hit;
        end
    end

    //--------------------------------------------------------------------------
    // Next state.
    //--------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_CLEAR: begin
                n_cnt = r_cnt + CW'(1);
                if (cnt_x == CMP_W'(MAX_ROWS - 1)) begin
                    n_state = S_IDLE;
                    n_cnt   = '0;
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    n_cnt   = '0;
                    n_state = (i_in.mode == MODE_STEP) ? S_STEP : S_ACCESS;
                end
            end
            S_ACCESS: n_state = S_DONE;
            S_STEP: begin
                n_cnt = r_cnt + CW'(1);
                if (cnt_x == rows_x + CMP_W'(3)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    //--------------------------------------------------------------------------
    // Memory control per state.
    // During a step, at count t the block reads row nr-1 (t = 0) or row t-1
    // (1 <= t <= nr), and writes new row t-4 (4 <= t <= nr+3). A row is always
    // read before it is rewritten, and the read and write rows never coincide.
    //--------------------------------------------------------------------------
    always_comb begin
        in_ready = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = RA_W'(r_cnt - CW'(1));
        wr_en    = 1'b0;
        wr_addr  = RA_W'(r_cnt - CW'(4));
        wr_data  = step_row;
        unique case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = RA_W'(r_cnt);
                wr_data = '0;
            end
            S_IDLE: begin
                in_ready = 1'b1;
                rd_en    = i_in.valid && in_hit;
                rd_addr  = RA_W'(i_in.row);
            end
            S_ACCESS: begin
                wr_en   = (r_mode == MODE_WRITE) && r_hit;
                wr_addr = RA_W'(r_row);
                wr_data = mod_word;
            end
            S_STEP: begin
                rd_en = (cnt_x <= rows_x);
                if (r_cnt == '0) begin
                    rd_addr = RA_W'(r_rows - CFG_W'(1));
                end
                wr_en = (cnt_x >= CMP_W'(4));
            end
            S_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_board[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_board[rd_addr];
        end
    end

    //--------------------------------------------------------------------------
    // Single cell access: bit merge for a write, bit pick for a read.
    //--------------------------------------------------------------------------
    assign col_idx = CA_W'(r_col);

    always_comb begin
        mod_word          = r_rd_data;
        mod_word[col_idx] = r_cell_in;
    end

    always_comb begin
        res_cell   = 1'b0;
        res_status = 1'b0;
        unique case (r_mode)
            MODE_WRITE: res_status = !r_hit;
            MODE_READ: begin
                res_cell   = r_hit && r_rd_data[col_idx];
                res_status = !r_hit;
            end
            default: ;
        endcase
    end

    //--------------------------------------------------------------------------
    // Step window. Read data is registered before it enters the window; the saved
    // old row 0 stands in for the last read, since row 0 is rewritten by then.
    //--------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_state == S_STEP) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= (cnt_x == rows_x + CMP_W'(2)) ? r_row0 : r_rd_data;
            if (cnt_x == CMP_W'(2)) begin
                r_row0 <= r_rd_data;
            end
        end
    end

    //--------------------------------------------------------------------------
    // New generation of the middle window row, all columns side by side.
    // Columns wrap at cols_in_use; columns beyond it keep their value.
    //--------------------------------------------------------------------------
    assign last_col = CA_W'(r_cols - CFG_W'(1));

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            nb_left[k][0] = r_win[k][last_col];
            for (int c = 1; c < MAX_COLS; c++) begin
                nb_left[k][c] = r_win[k][c-1];
            end
            for (int c = 0; c < MAX_COLS - 1; c++) begin
                nb_right[k][c] = ((c + 1) >= int'(r_cols)) ? r_win[k][0] : r_win[k][c+1];
            end
            nb_right[k][MAX_COLS-1] = r_win[k][0];
        end
    end

    always_comb begin
        for (int c = 0; c < MAX_COLS; c++) begin
            nsum[c] = {3'b000, nb_left[0][c]} + {3'b000, r_win[0][c]} +
                      {3'b000, nb_right[0][c]} + {3'b000, nb_left[1][c]} +
                      {3'b000, nb_right[1][c]} + {3'b000, nb_left[2][c]} +
                      {3'b000, r_win[2][c]} + {3'b000, nb_right[2][c]};
            if (c >= int'(r_cols)) begin
                step_row[c] = r_win[1][c];
            end else begin
                step_row[c] = (nsum[c] == BIRTH_COUNT) ||
                              (r_win[1][c] && (nsum[c] == SURVIVE_COUNT));
            end
        end
    end

    //--------------------------------------------------------------------------
    // Results. A finished result waits here until the output register is free.
    //--------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_state == S_ACCESS) begin
            r_res_cell   <= res_cell;
            r_res_status <= res_status;
        end else if (r_state == S_STEP) begin
            r_res_cell   <= 1'b0;
            r_res_status <= 1'b0;
        end
    end

    assign out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_cell   <= r_res_cell;
            r_out_status <= r_res_status;
        end
    end

    assign i_in.ready     = in_ready;
    assign o_out.valid    = r_out_valid;
    assign o_out.cell_out = r_out_cell;
    assign o_out.status   = r_out_status;

    //--------------------------------------------------------------------------
    // Assertions.
    //--------------------------------------------------------------------------
`include "assert_macros.svh"

    `ASSERT_CLK(a_rw_clash, (rd_en && wr_en) |-> (rd_addr != wr_addr), "row read while written")
    `ASSERT_CLK(a_out_hold, r_state == S_DONE && !out_free |=> r_state == S_DONE, "result overran")
    `ASSERT_ALWAYS(a_clr, !i_rst_n |=> r_state == S_CLEAR && r_cnt == '0, "clear not restarted")

endmodule

>>> test/lts_checker.sv
//==============================================================================
// Toroidal life board checker
// Watches the command, result and configuration ports, predicts every result
// from a private copy of the board and compares it with what the block returns.
//==============================================================================
module lts_checker #(
    parameter int BOARD_ROWS = 64,
    parameter int BOARD_COLS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    lts_in_if                             i_cmd,
    lts_out_if                            i_res,
    input  logic                          i_cfg_we,
    input  logic [lts_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lts_pkg::CFG_W-1:0]     i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import lts_pkg::*;

    typedef struct packed {
        logic cell_out;
        logic status;
    } t_cell_result;

    logic [BOARD_COLS-1:0] cells [BOARD_ROWS];
    int unsigned           rows_used;
    int unsigned           cols_used;
    t_cell_result          awaited_results [$];
    int                    mismatches = 0;
    int                    results_seen = 0;

    assign o_fail_count = mismatches;

    // A size of zero means one; anything past the board means the whole board.
    function automatic int unsigned fit_size(logic [CFG_W-1:0] raw, int unsigned limit);
        if (raw == '0) return 1;
        if (raw > limit) return limit;
        return raw;
    endfunction

    // One B3/S23 generation over the active region, wrapping at its edges.
    function automatic void next_generation();
        logic [BOARD_COLS-1:0] prior [BOARD_ROWS];
        int unsigned up, dn, lf, rt, live;
        prior = cells;
        for (int unsigned r = 0; r < rows_used; r++) begin
            up = (r == 0) ? rows_used - 1 : r - 1;
            dn = (r + 1 >= rows_used) ? 0 : r + 1;
            for (int unsigned c = 0; c < cols_used; c++) begin
                lf = (c == 0) ? cols_used - 1 : c - 1;
                rt = (c + 1 >= cols_used) ? 0 : c + 1;
                live = prior[up][lf] + prior[up][c] + prior[up][rt]
                     + prior[r][lf]                 + prior[r][rt]
                     + prior[dn][lf] + prior[dn][c] + prior[dn][rt];
                if (prior[r][c]) begin
                    cells[r][c] = (live == 2 || live == 3);
                end else begin
                    cells[r][c] = (live == 3);
                end
            end
        end
    endfunction

    function automatic t_cell_result apply_command(logic [MODE_W-1:0] mode,
                                                   logic [COORD_W-1:0] row,
                                                   logic [COORD_W-1:0] col,
                                                   logic cell_in);
        t_cell_result res;
        res = '0;
        case (mode) inside
            MODE_STEP: begin
                next_generation();
            end
            MODE_WRITE, MODE_READ: begin
                if (row >= rows_used || col >= cols_used) begin
                    res.status = 1'b1;
                end else if (mode == MODE_WRITE) begin
                    cells[row][col] = cell_in;
                end else begin
                    res.cell_out = cells[row][col];
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] board check, result %0d: %s", $realtime, results_seen, what);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_cell_result want;
        if (!i_rst_n) begin
            foreach (cells[r]) cells[r] = '0;
            rows_used = fit_size(CFG_W'(RESET_SIZE), BOARD_ROWS);
            cols_used = fit_size(CFG_W'(RESET_SIZE), BOARD_COLS);
            awaited_results.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_ROWS) begin
                    rows_used = fit_size(i_cfg_data, BOARD_ROWS);
                end else if (i_cfg_idx == CFG_COLS) begin
                    cols_used = fit_size(i_cfg_data, BOARD_COLS);
                end
            end
            // Results leave before the command of this edge is counted, so a
            // result can never be matched with a command taken at the same edge.
            if (i_res.valid && i_res.ready) begin
                results_seen++;
                if (awaited_results.size() == 0) begin
                    report_mismatch("result transaction with no command waiting");
                end else begin
                    want = awaited_results.pop_front();
                    if (i_res.cell_out !== want.cell_out) begin
                        report_mismatch($sformatf("cell_out %b, expected %b",
                                                  i_res.cell_out, want.cell_out));
                    end
                    if (i_res.status !== want.status) begin
                        report_mismatch($sformatf("status %b, expected %b",
                                                  i_res.status, want.status));
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                awaited_results.push_back(apply_command(i_cmd.mode, i_cmd.row,
                                                        i_cmd.col, i_cmd.cell_in));
            end
        end
        o_pending <= awaited_results.size();
    end

endmodule

>>> test/tb_top.sv
//==============================================================================
// Toroidal life board testbench
// Drives write, step and read commands through a run of board sizes, with
// random idling on both channels, and reports the checker's verdict.
//==============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lts_pkg::*;

    localparam int BOARD_DIM       = 64;
    // No transaction for this many cycles means the block has hung. The limit is
    // far above a step of the largest board or the clearing pass after reset,
    // so it leaves a wide margin even with stalls around them.
    localparam int STALL_LIMIT     = 2000;
    // Cycles watched after the last result for anything unexpected.
    localparam int DRAIN_CYCLES    = 80;
    localparam int ITEMS_PER_PHASE = 64;
    localparam int RANDOM_PHASES   = 7;

    // The mode field has one code that the block does not use.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // Raw register values of the planned phases. Zero, values past the board
    // and all-ones exercise the clamping; the thin shapes exercise wrapping
    // onto the same cell.
    localparam int PLAN_LEN = 11;
    localparam int PLAN_ROWS [PLAN_LEN] = '{0, 1, 2, 1, 64, 2, 3, 127, 64, 65, 5};
    localparam int PLAN_COLS [PLAN_LEN] = '{0, 1, 2, 64, 1, 5, 3, 127, 64, 7, 100};

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;
    // Enables random idling on both channels for the current phase.
    logic                 gaps_on;

    int                   fail_count;
    int                   pending;
    int unsigned          idle_cycles = 0;

    // Region in use as the block sees it, used only to aim the stimulus.
    int unsigned          rows_now;
    int unsigned          cols_now;

    lts_in_if  cmd_ch ();
    lts_out_if res_ch ();

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    life_automaton_toroidal_step #(
        .MAX_ROWS (BOARD_DIM),
        .MAX_COLS (BOARD_DIM)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (cmd_ch),
        .o_out      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    lts_checker #(
        .BOARD_ROWS (BOARD_DIM),
        .BOARD_COLS (BOARD_DIM)
    ) u_board_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cmd        (cmd_ch),
        .i_res        (res_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // The result side holds ready at one level for a random burst, low about a
    // third of the time. With idling off it simply takes every result as soon
    // as it appears.
    initial begin
        int unsigned burst;
        res_ch.ready <= 1'b0;
        burst = 0;
        forever begin
            @(posedge clk);
            if (!rst_n || !gaps_on) begin
                res_ch.ready <= 1'b1;
                burst = 0;
            end else if (burst != 0) begin
                burst--;
            end else begin
                res_ch.ready <= ($urandom_range(0, 2) == 0) ? 1'b0 : 1'b1;
                burst = $urandom_range(0, 7);
            end
        end
    end

    // Watchdog: a hung handshake on either channel ends the run.
    always @(posedge clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int unsigned size_in_use(int raw);
        if (raw == 0) return 1;
        if (raw > BOARD_DIM) return BOARD_DIM;
        return raw;
    endfunction

    // Half of the coordinates land in a small patch around a focus point, so
    // that live cells cluster and steps have real neighborhoods to work on
    // even on the largest board.
    function automatic logic [COORD_W-1:0] pick_coord(int unsigned span, int unsigned focus);
        if ($urandom_range(0, 1) == 1) begin
            return COORD_W'((focus + $urandom_range(0, 3)) % span);
        end
        return COORD_W'($urandom_range(0, span - 1));
    endfunction

    // Presents one command and returns at the edge where it is accepted. An
    // idle burst, when one is drawn, drops valid first; otherwise valid stays
    // high straight into the next transaction.
    task automatic issue(input logic [MODE_W-1:0] mode, input logic [COORD_W-1:0] row,
                         input logic [COORD_W-1:0] col, input logic cell_in);
        int unsigned gap;
        gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
        if (gap != 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.mode    <= mode;
        cmd_ch.row     <= row;
        cmd_ch.col     <= col;
        cmd_ch.cell_in <= cell_in;
        @(posedge clk);
        while (cmd_ch.ready !== 1'b1) @(posedge clk);
    endtask

    // The checker's count is registered, so it is trusted to include the last
    // command only after the next clock edge has passed.
    task automatic wait_for_results();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Sizes change only once the board is idle: no command in flight and
    // every result collected.
    task automatic resize(input int raw_rows, input int raw_cols);
        cmd_ch.valid <= 1'b0;
        wait_for_results();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_ROWS;
        cfg_data <= CFG_W'(raw_rows);
        @(posedge clk);
        cfg_idx  <= CFG_COLS;
        cfg_data <= CFG_W'(raw_cols);
        @(posedge clk);
        cfg_we   <= 1'b0;
        rows_now = size_in_use(raw_rows);
        cols_now = size_in_use(raw_cols);
    endtask

    // One phase of random commands. Small boards are seeded in full first so
    // that steps start from a populated region. The mix is mostly writes,
    // reads and steps inside the region, with a share of commands that miss
    // the region and of the unused mode.
    task automatic random_phase(input int unsigned count);
        int unsigned pick;
        int unsigned focus_row;
        int unsigned focus_col;
        int unsigned live_pct;
        focus_row = $urandom_range(0, rows_now - 1);
        focus_col = $urandom_range(0, cols_now - 1);
        live_pct  = $urandom_range(15, 60);
        if (rows_now * cols_now <= 64) begin
            for (int unsigned fr = 0; fr < rows_now; fr++) begin
                for (int unsigned fc = 0; fc < cols_now; fc++) begin
                    issue(MODE_WRITE, COORD_W'(fr), COORD_W'(fc),
                          $urandom_range(0, 99) < live_pct);
                end
            end
        end
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                issue(MODE_WRITE, pick_coord(rows_now, focus_row),
                      pick_coord(cols_now, focus_col), $urandom_range(0, 99) < live_pct);
            end else if (pick < 50) begin
                issue(MODE_STEP, COORD_W'($urandom), COORD_W'($urandom), 1'($urandom));
            end else if (pick < 88) begin
                issue(MODE_READ, pick_coord(rows_now, focus_row),
                      pick_coord(cols_now, focus_col), 1'($urandom));
            end else if (pick < 96) begin
                // Full-range coordinates: mostly outside any small region.
                issue(($urandom_range(0, 1) == 1) ? MODE_WRITE : MODE_READ,
                      COORD_W'($urandom), COORD_W'($urandom), 1'($urandom));
            end else begin
                issue(MODE_UNUSED, COORD_W'($urandom), COORD_W'($urandom), 1'($urandom));
            end
        end
    endtask

    initial begin
        int raw_rows;
        int raw_cols;
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_idx        <= CFG_ROWS;
        cfg_data       <= '0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.mode    <= MODE_WRITE;
        cmd_ch.row     <= '0;
        cmd_ch.col     <= '0;
        cmd_ch.cell_in <= 1'b0;
        gaps_on        <= 1'b0;
        rows_now = RESET_SIZE;
        cols_now = RESET_SIZE;
        repeat (9) @(posedge clk);
        rst_n   <= 1'b1;
        gaps_on <= 1'b1;

        // Directed part on the 10 x 10 board left by reset. The first command
        // waits out the clearing pass and must read a dead cell.
        issue(MODE_READ,   6'd0,  6'd0,  1'b0);
        // Coordinates outside the region are flagged and leave the board alone,
        // including the first row and column just past the edge.
        issue(MODE_WRITE,  6'd63, 6'd63, 1'b1);
        issue(MODE_READ,   6'd63, 6'd63, 1'b0);
        issue(MODE_WRITE,  6'd10, 6'd0,  1'b1);
        issue(MODE_READ,   6'd0,  6'd10, 1'b0);
        issue(MODE_UNUSED, 6'd63, 6'd63, 1'b1);
        // A horizontal blinker that straddles the column wrap turns vertical
        // and straddles the row wrap after one step.
        issue(MODE_WRITE,  6'd0,  6'd9,  1'b1);
        issue(MODE_WRITE,  6'd0,  6'd0,  1'b1);
        issue(MODE_WRITE,  6'd0,  6'd1,  1'b1);
        issue(MODE_STEP,   6'd0,  6'd0,  1'b0);
        issue(MODE_READ,   6'd9,  6'd0,  1'b0);
        issue(MODE_READ,   6'd0,  6'd0,  1'b0);
        issue(MODE_READ,   6'd1,  6'd0,  1'b0);
        issue(MODE_READ,   6'd0,  6'd9,  1'b0);
        // Far corner of the region, then a step whose unused fields are all ones.
        issue(MODE_WRITE,  6'd9,  6'd9,  1'b1);
        issue(MODE_STEP,   6'd63, 6'd63, 1'b1);
        issue(MODE_READ,   6'd9,  6'd9,  1'b0);
        issue(MODE_READ,   6'd0,  6'd0,  1'b0);
        issue(MODE_WRITE,  6'd0,  6'd0,  1'b0);
        issue(MODE_READ,   6'd0,  6'd0,  1'b0);

        // Planned sizes, each followed by a phase of random commands. Some
        // phases run without idling at all.
        for (int p = 0; p < PLAN_LEN; p++) begin
            resize(PLAN_ROWS[p], PLAN_COLS[p]);
            gaps_on <= ($urandom_range(0, 3) != 0);
            random_phase(ITEMS_PER_PHASE);
        end

        // Random sizes, mostly small so that steps stay short and dense.
        repeat (RANDOM_PHASES) begin
            raw_rows = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                   : $urandom_range(3, 16);
            raw_cols = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                   : $urandom_range(3, 16);
            resize(raw_rows, raw_cols);
            gaps_on <= ($urandom_range(0, 3) != 0);
            random_phase(ITEMS_PER_PHASE);
        end

        // Last phase runs at full rate on both channels.
        resize(8, 8);
        gaps_on <= 1'b0;
        random_phase(ITEMS_PER_PHASE);

        cmd_ch.valid <= 1'b0;
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
